@@ rtl/core/gray_qam_psk_symbol_mapper_unit_macros.svh @@
// assertion macros for the symbol mapper
`ifndef GRAY_QAM_PSK_SYMBOL_MAPPER_UNIT_MACROS_SVH
`define GRAY_QAM_PSK_SYMBOL_MAPPER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define GQPM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GQPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/gqpm_pkg.sv @@
`default_nettype none

package gqpm_pkg;

	// fixed field widths
	localparam int SYM_W       = 8;
	localparam int BITS_W      = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 4;

	// parameter defaults
	localparam int MAX_BITS_DEF     = 8;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// register reset values
	localparam logic [BITS_W-1:0] BITS_RESET = 4'd4;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MODULATION_KIND = 1'b0,
		CFG_BITS_PER_SYMBOL = 1'b1
	} cfg_reg_t;

	// modulation selection
	typedef enum logic {
		MOD_QAM = 1'b0,
		MOD_PSK = 1'b1
	} mod_kind_t;

	// mapping request handed to both mappers
	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [BITS_W-1:0] bits;
	} map_req_t;

	// q30 coefficients of the odd sine polynomial
	localparam longint unsigned COEF1 = 64'd1686629713;
	localparam longint unsigned COEF3 = 64'd693598668;
	localparam longint unsigned COEF5 = 64'd85569306;
	localparam longint unsigned COEF7 = 64'd5026995;
	localparam longint unsigned COEF9 = 64'd172272;

	// sine magnitude of a first-quadrant q30 angle, scaled to fs and clamped
	function automatic longint unsigned sine_mag(input longint unsigned x,
		input longint unsigned fs);
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned mag;
		x2 = (x * x) >> 30;
		t = COEF9;
		t = COEF7 - ((x2 * t) >> 30);
		t = COEF5 - ((x2 * t) >> 30);
		t = COEF3 - ((x2 * t) >> 30);
		t = COEF1 - ((x2 * t) >> 30);
		s = (x * t) >> 30;
		mag = (s * fs + (64'd1 << 29)) >> 30;
		if (mag > fs) begin
			mag = fs;
		end
		return mag;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/gqpm_qam_map.sv @@
`default_nettype none

module gqpm_qam_map #(
	parameter int MAX_BITS     = gqpm_pkg::MAX_BITS_DEF,
	parameter int SAMPLE_WIDTH = gqpm_pkg::SAMPLE_WIDTH_DEF
) (
	input  var gqpm_pkg::map_req_t           req,
	output logic signed [SAMPLE_WIDTH-1:0]   in_level,
	output logic signed [SAMPLE_WIDTH-1:0]   quad_level
);

	localparam int HALF_MAX  = MAX_BITS / 2;
	localparam int HALF_W    = HALF_MAX;
	localparam int IDX_W     = HALF_MAX + 1;
	localparam int ROM_DEPTH = 1 << IDX_W;
	localparam longint FS    = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;

	// prefix xor from the msb down
	function automatic logic [HALF_W-1:0] gray_decode(input logic [HALF_W-1:0] g);
		logic [HALF_W-1:0] v;
		v = g;
		for (int i = HALF_W - 2; i >= 0; i--) begin
			v[i] = v[i+1] ^ g[i];
		end
		return v;
	endfunction

	logic signed [SAMPLE_WIDTH-1:0] lvl_rom [ROM_DEPTH];
	logic [2:0]                     half;
	logic [gqpm_pkg::SYM_W-1:0]     row_full;
	logic [gqpm_pkg::SYM_W-1:0]     col_mask;
	logic [HALF_W-1:0]              row;
	logic [HALF_W-1:0]              col;
	logic [IDX_W-1:0]               base;
	logic [IDX_W-1:0]               row_idx;
	logic [IDX_W-1:0]               col_idx;

	// level table, one segment per order, segment base is 2^half
	assign lvl_rom[0] = '0;
	assign lvl_rom[1] = '0;
	for (genvar h = 1; h <= HALF_MAX; h++) begin : g_order
		for (genvar k = 0; k < (1 << h); k++) begin : g_level
			localparam longint D    = (longint'(1) << h) - 1;
			localparam longint TWOK = 2 * k;
			localparam bit     NEG  = TWOK < D;
			localparam longint DIFF = NEG ? (D - TWOK) : (TWOK - D);
			localparam longint MAG  = (2 * DIFF * FS + D) / (2 * D);
			localparam longint VAL  = NEG ? -MAG : MAG;
			assign lvl_rom[(1 << h) + k] = SAMPLE_WIDTH'(VAL);
		end
	end

	// split the symbol into gray coded row and column
	assign half     = req.bits[gqpm_pkg::BITS_W-1:1];
	assign row_full = req.symbol >> half;
	assign col_mask = (gqpm_pkg::SYM_W'(1) << half) - gqpm_pkg::SYM_W'(1);
	assign row      = gray_decode(row_full[HALF_W-1:0]);
	assign col      = gray_decode(HALF_W'(req.symbol & col_mask));

	// table lookup, q axis runs top to bottom
	assign base       = IDX_W'(1) << half;
	assign col_idx    = base + IDX_W'(col);
	assign row_idx    = base + IDX_W'(row);
	assign in_level   = lvl_rom[col_idx];
	assign quad_level = -lvl_rom[row_idx];

endmodule

`default_nettype wire

@@ rtl/core/gqpm_psk_map.sv @@
`default_nettype none

module gqpm_psk_map #(
	parameter int MAX_BITS     = gqpm_pkg::MAX_BITS_DEF,
	parameter int SAMPLE_WIDTH = gqpm_pkg::SAMPLE_WIDTH_DEF
) (
	input  var gqpm_pkg::map_req_t           req,
	output logic signed [SAMPLE_WIDTH-1:0]   cos_sample,
	output logic signed [SAMPLE_WIDTH-1:0]   sin_sample
);

	localparam int N_W       = MAX_BITS + 1;
	localparam int IDX_W     = MAX_BITS;
	localparam int MAG_W     = SAMPLE_WIDTH - 1;
	localparam int SH_W      = $clog2(MAX_BITS + 1);
	localparam int QUARTER   = 1 << (MAX_BITS - 1);
	localparam int ROM_DEPTH = QUARTER + 1;
	localparam longint unsigned FS = (64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1;

	logic [MAG_W-1:0]                 sin_rom [ROM_DEPTH];
	logic [gqpm_pkg::SYM_W-1:0]       gray;
	logic [SH_W-1:0]                  shamt;
	logic [N_W-1:0]                   phase [2];
	logic signed [SAMPLE_WIDTH-1:0]   sample [2];

	// first quadrant magnitudes, angle grid of 2^(31-MAX_BITS)
	for (genvar i = 0; i < ROM_DEPTH; i++) begin : g_rom
		localparam longint unsigned MAG =
			gqpm_pkg::sine_mag(64'(i) << (31 - MAX_BITS), FS);
		assign sin_rom[i] = MAG_W'(MAG);
	end

	// phase on the finest grid: (2*gray+1) scaled up to MAX_BITS
	assign gray     = req.symbol ^ (req.symbol >> 1);
	assign shamt    = SH_W'(MAX_BITS) - SH_W'(req.bits);
	assign phase[0] = N_W'({gray, 1'b1}) << shamt;
	assign phase[1] = phase[0] + N_W'(QUARTER);

	// quadrant folding, lane 0 sine, lane 1 cosine
	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [1:0]          quad;
		logic [IDX_W-1:0]    r;
		logic [IDX_W-1:0]    idx;
		logic signed [SAMPLE_WIDTH-1:0] mag;
		assign quad      = phase[l][N_W-1 -: 2];
		assign r         = IDX_W'(phase[l][MAX_BITS-2:0]);
		assign idx       = quad[0] ? (IDX_W'(QUARTER) - r) : r;
		assign mag       = {1'b0, sin_rom[idx]};
		assign sample[l] = quad[1] ? -mag : mag;
	end

	assign sin_sample = sample[0];
	assign cos_sample = sample[1];

endmodule

`default_nettype wire

@@ rtl/core/gray_qam_psk_symbol_mapper_unit.sv @@
// stages: input register, table lookup, result register
// throughput: one symbol per cycle unless out_ready stalls the result register
// in_ready falls only when both registers hold work and out_ready is low
// reset: asynchronous, active low; clears both valid flags, selects square qam
// and four bits per symbol
`default_nettype none

module gray_qam_psk_symbol_mapper_unit #(
	parameter int MAX_BITS     = gqpm_pkg::MAX_BITS_DEF,
	parameter int SAMPLE_WIDTH = gqpm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [gqpm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [gqpm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [gqpm_pkg::SYM_W-1:0]            symbol,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]        in_phase,
	output logic signed [SAMPLE_WIDTH-1:0]        quadrature,
	output logic                                  invalid
);

	gqpm_pkg::mod_kind_t               kind_q;
	logic [gqpm_pkg::BITS_W-1:0]       bits_q;
	logic [gqpm_pkg::SYM_W-1:0]        sym_s1;
	logic                              valid_s1;
	logic signed [SAMPLE_WIDTH-1:0]    i_s2;
	logic signed [SAMPLE_WIDTH-1:0]    q_s2;
	logic                              inv_s2;
	logic                              valid_s2;
	logic                              adv_s2;
	gqpm_pkg::map_req_t                req;
	logic                              bad;
	logic signed [SAMPLE_WIDTH-1:0]    qam_i;
	logic signed [SAMPLE_WIDTH-1:0]    qam_q;
	logic signed [SAMPLE_WIDTH-1:0]    psk_i;
	logic signed [SAMPLE_WIDTH-1:0]    psk_q;
	logic signed [SAMPLE_WIDTH-1:0]    i_next;
	logic signed [SAMPLE_WIDTH-1:0]    q_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= gqpm_pkg::MOD_QAM;
			bits_q <= gqpm_pkg::BITS_RESET;
		end else if (cfg_write) begin
			case (gqpm_pkg::cfg_reg_t'(cfg_index))
				gqpm_pkg::CFG_MODULATION_KIND: begin
					kind_q <= gqpm_pkg::mod_kind_t'(cfg_data[0]);
				end
				gqpm_pkg::CFG_BITS_PER_SYMBOL: begin
					bits_q <= cfg_data;
				end
				default: begin
					bits_q <= bits_q;
				end
			endcase
		end
	end

	// handshake: the result register frees up when empty or taken
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sym_s1 <= symbol;
		end
	end

	// mappers
	assign req = '{symbol: sym_s1, bits: bits_q};

	gqpm_qam_map #(
		.MAX_BITS     (MAX_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_qam (
		.req        (req),
		.in_level   (qam_i),
		.quad_level (qam_q)
	);

	gqpm_psk_map #(
		.MAX_BITS     (MAX_BITS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_psk (
		.req        (req),
		.cos_sample (psk_i),
		.sin_sample (psk_q)
	);

	// range checks and result selection
	assign bad = (bits_q == '0)
		|| (bits_q > gqpm_pkg::BITS_W'(MAX_BITS))
		|| ((sym_s1 >> bits_q) != '0)
		|| ((kind_q == gqpm_pkg::MOD_QAM) && bits_q[0]);

	always_comb begin
		i_next = '0;
		q_next = '0;
		if (!bad) begin
			case (kind_q)
				gqpm_pkg::MOD_QAM: begin
					i_next = qam_i;
					q_next = qam_q;
				end
				gqpm_pkg::MOD_PSK: begin
					i_next = psk_i;
					q_next = psk_q;
				end
				default: begin
					i_next = '0;
					q_next = '0;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			i_s2   <= i_next;
			q_s2   <= q_next;
			inv_s2 <= bad;
		end
	end

	assign out_valid  = valid_s2;
	assign in_phase   = i_s2;
	assign quadrature = q_s2;
	assign invalid    = inv_s2;

endmodule

`default_nettype wire

@@ rtl/core/gqpm_port_checker.sv @@
`default_nettype none
`include "gray_qam_psk_symbol_mapper_unit_macros.svh"

module gqpm_port_checker #(
	parameter int SAMPLE_WIDTH = gqpm_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [SAMPLE_WIDTH-1:0] in_phase,
	input logic signed [SAMPLE_WIDTH-1:0] quadrature,
	input logic                           invalid
);

	localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// a rejected request always reads as the origin
	`GQPM_ASSERT_IMPL(a_invalid_zero, clk, arst_n, out_valid && invalid, (in_phase == '0) && (quadrature == '0), "invalid result with nonzero sample")

	// samples stay within plus or minus full scale
	`GQPM_ASSERT_IMPL(a_no_most_neg, clk, arst_n, out_valid, (in_phase != MOST_NEG) && (quadrature != MOST_NEG), "sample beyond negative full scale")

	// an empty result register never blocks the input
	`GQPM_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready, "input stalled while no result is held")

	// a stalled result holds its transaction
	`GQPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(in_phase) && $stable(quadrature) && $stable(invalid), "stalled result changed")

endmodule

bind gray_qam_psk_symbol_mapper_unit gqpm_port_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_port_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.in_phase   (in_phase),
	.quadrature (quadrature),
	.invalid    (invalid)
);

`default_nettype wire

@@ tb/gray_qam_psk_symbol_mapper_unit_tb.sv @@
`timescale 1ns / 100ps

module gray_qam_psk_symbol_mapper_unit_tb;
	import gqpm_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int MAXB = MAX_BITS_DEF;
	localparam longint unsigned FS = (64'd1 << (SW - 1)) - 64'd1;
	localparam int LIMIT_CYCLES = 400000;
	localparam int RANDOM_ITEMS = 650;

	// one constellation point as the block should report it
	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic [SW-1:0]    i_val;
		logic [SW-1:0]    q_val;
		logic             bad;
	} iq_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SYM_W-1:0] symbol = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SW-1:0] in_phase;
	logic signed [SW-1:0] quadrature;
	logic invalid;

	// register copies used for prediction
	mod_kind_t mod_sel = MOD_QAM;
	logic [BITS_W-1:0] bits_sel = BITS_RESET;

	logic [SYM_W-1:0] sym_pending[$];
	iq_point_t expected_points[$];
	iq_point_t want;

	int n_sent = 0;
	int n_accepted = 0;
	int n_taken = 0;
	int n_taken_seen = 0;
	int n_points = 0;
	int n_errors = 0;
	int n_settings = 0;
	int n_queued = 0;
	int n_cycles = 0;
	int send_gap = 0;
	int hold_cnt = 0;
	bit idle_on = 1'b1;

	gray_qam_psk_symbol_mapper_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.in_phase   (in_phase),
		.quadrature (quadrature),
		.invalid    (invalid)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// clamp a magnitude to full scale and apply the sign
	function automatic logic [SW-1:0] signed_sample(input bit neg, input longint unsigned mag);
		logic [SW-1:0] m;
		if (mag > FS) begin
			mag = FS;
		end
		m = mag[SW-1:0];
		return neg ? -m : m;
	endfunction

	// binary value of a gray code
	function automatic int unsigned gray_decode(input int unsigned g);
		int unsigned v;
		v = 0;
		while (g != 0) begin
			v ^= g;
			g >>= 1;
		end
		return v;
	endfunction

	// one qam axis level, rounded half away from zero
	function automatic logic [SW-1:0] qam_axis(input longint unsigned k,
		input longint unsigned lev, input bit flip);
		longint unsigned d;
		longint unsigned diff;
		longint unsigned mag;
		bit neg;
		d = lev - 1;
		neg = (2 * k) < d;
		diff = neg ? (d - 2 * k) : (2 * k - d);
		mag = (2 * diff * FS + d) / (2 * d);
		return signed_sample(neg != flip, mag);
	endfunction

	// sine of a 32-bit phase word via the q30 odd polynomial
	function automatic logic [SW-1:0] psk_sine(input logic [31:0] phase);
		logic [1:0] quad;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned mag;
		quad = phase[31:30];
		x = quad[0] ? ((64'd1 << 30) - {34'd0, phase[29:0]}) : {34'd0, phase[29:0]};
		x2 = (x * x) >> 30;
		t = COEF9;
		t = COEF7 - ((x2 * t) >> 30);
		t = COEF5 - ((x2 * t) >> 30);
		t = COEF3 - ((x2 * t) >> 30);
		t = COEF1 - ((x2 * t) >> 30);
		s = (x * t) >> 30;
		mag = (s * FS + (64'd1 << 29)) >> 30;
		return signed_sample(quad[1], mag);
	endfunction

	// expected point for one symbol under the current register values
	function automatic iq_point_t map_symbol(input logic [SYM_W-1:0] sym);
		iq_point_t p;
		int unsigned b;
		int unsigned half;
		int unsigned lev;
		logic [8:0] code;
		logic [31:0] phase;
		p = '0;
		p.sym = sym;
		b = bits_sel;
		if (b == 0 || b > MAXB || (int'(sym) >> b) != 0 || (mod_sel == MOD_QAM && b % 2 == 1)) begin
			p.bad = 1'b1;
			return p;
		end
		if (mod_sel == MOD_QAM) begin
			half = b / 2;
			lev = 1 << half;
			p.i_val = qam_axis(gray_decode(int'(sym) & (lev - 1)), lev, 1'b0);
			p.q_val = qam_axis(gray_decode(int'(sym) >> half), lev, 1'b1);
		end else begin
			code = {sym ^ (sym >> 1), 1'b1};
			phase = {23'd0, code} << (31 - b);
			p.i_val = psk_sine(phase + 32'h4000_0000);
			p.q_val = psk_sine(phase);
		end
		return p;
	endfunction

	// symbol driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || n_accepted == n_sent) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (sym_pending.size() != 0) begin
					symbol <= sym_pending.pop_front();
					in_valid <= 1'b1;
					n_sent++;
					send_gap = idle_on ? $urandom_range(0, 13) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver with random stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_taken_seen != n_taken) begin
				n_taken_seen = n_taken;
				hold_cnt = idle_on ? $urandom_range(0, 13) : 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor: check results, then record accepted symbols
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("gray_qam_psk_symbol_mapper_unit_tb: FAIL");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_taken++;
				if (expected_points.size() == 0) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("unexpected result I=%0d Q=%0d invalid=%b",
							in_phase, quadrature, invalid);
					end
				end else begin
					want = expected_points.pop_front();
					n_points++;
					if (in_phase !== want.i_val || quadrature !== want.q_val
						|| invalid !== want.bad) begin
						n_errors++;
						if (n_errors <= 10) begin
							$display("mismatch sym=%0d: expected I=%0d Q=%0d invalid=%b, got I=%0d Q=%0d invalid=%b",
								want.sym, $signed(want.i_val), $signed(want.q_val), want.bad,
								in_phase, quadrature, invalid);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_points.push_back(map_symbol(symbol));
				n_accepted++;
			end
		end
	end

	// wait until every transaction has drained
	task automatic wait_idle();
		while (sym_pending.size() != 0 || n_accepted != n_sent || in_valid
			|| expected_points.size() != 0) begin
			@(negedge clk);
		end
		repeat (3) @(negedge clk);
	endtask

	// write both registers while the block is idle
	task automatic apply_setting(input mod_kind_t mod, input logic [BITS_W-1:0] bits);
		wait_idle();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_MODULATION_KIND;
		cfg_data <= {{(CFG_DATA_W-1){1'b0}}, mod};
		@(negedge clk);
		cfg_index <= CFG_BITS_PER_SYMBOL;
		cfg_data <= bits;
		@(negedge clk);
		cfg_write <= 1'b0;
		mod_sel = mod;
		bits_sel = bits;
		n_settings++;
	endtask

	task automatic queue_symbol(input logic [SYM_W-1:0] sym);
		sym_pending.push_back(sym);
		n_queued++;
	endtask

	// random phase: mostly in-range symbols, some arbitrary bytes
	task automatic random_phase(input mod_kind_t mod, input logic [BITS_W-1:0] bits,
		input int count);
		int unsigned b;
		apply_setting(mod, bits);
		idle_on = ($urandom_range(0, 3) != 0);
		b = bits;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 9) == 0 || b == 0 || b >= SYM_W) begin
				queue_symbol($urandom_range(0, 255));
			end else begin
				queue_symbol($urandom_range(0, (1 << b) - 1));
			end
		end
	endtask

	// stimulus
	initial begin
		mod_kind_t mod;
		logic [BITS_W-1:0] bits;
		int target;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset setting: 16-qam corner and inner points, out of range symbols
		queue_symbol(8'd0);
		queue_symbol(8'd15);
		queue_symbol(8'd5);
		queue_symbol(8'd10);
		queue_symbol(8'd16);
		queue_symbol(8'd255);

		// smallest qam order
		apply_setting(MOD_QAM, 4'd2);
		for (int s = 0; s < 5; s++) begin
			queue_symbol(s);
		end

		// largest qam order
		apply_setting(MOD_QAM, 4'd8);
		queue_symbol(8'd0);
		queue_symbol(8'd255);
		queue_symbol(8'hAA);

		// bpsk, with a symbol out of range
		apply_setting(MOD_PSK, 4'd1);
		queue_symbol(8'd0);
		queue_symbol(8'd1);
		queue_symbol(8'd2);

		// largest psk order
		apply_setting(MOD_PSK, 4'd8);
		queue_symbol(8'd0);
		queue_symbol(8'd255);
		queue_symbol(8'h80);

		// odd qam order, zero bits, orders above the limit
		apply_setting(MOD_QAM, 4'd3);
		queue_symbol(8'd1);
		apply_setting(MOD_PSK, 4'd0);
		queue_symbol(8'd0);
		apply_setting(MOD_PSK, 4'd9);
		queue_symbol(8'd0);
		apply_setting(MOD_QAM, 4'd15);
		queue_symbol(8'd0);

		// random phases, extremes first
		target = n_queued + RANDOM_ITEMS;
		random_phase(MOD_QAM, 4'd8, $urandom_range(30, 80));
		random_phase(MOD_PSK, 4'd8, $urandom_range(30, 80));
		while (n_queued < target) begin
			mod = mod_kind_t'($urandom_range(0, 1));
			if ($urandom_range(0, 9) == 0) begin
				bits = $urandom_range(0, 15);
			end else if (mod == MOD_QAM) begin
				bits = 2 * $urandom_range(1, 4);
			end else begin
				bits = $urandom_range(1, 8);
			end
			random_phase(mod, bits, $urandom_range(30, 80));
		end

		wait_idle();
		repeat (5) @(posedge clk);
		$display("%0d symbols sent over %0d register settings, %0d points checked, %0d errors",
			n_sent, n_settings, n_points, n_errors);
		if (n_errors == 0 && expected_points.size() == 0) begin
			$display("gray_qam_psk_symbol_mapper_unit_tb: PASS");
		end else begin
			$display("gray_qam_psk_symbol_mapper_unit_tb: FAIL");
		end
		$finish;
	end

endmodule
